// File: sv/psal_pkg.sv
// Shared types and constants of the per-source attempt limiter.
// Used by every module of the block but psal_ram; depends on nothing.
package psal_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_ADDR_W = 2;

    // commands
    localparam logic [1:0] CMD_CHECK   = 2'd0;
    localparam logic [1:0] CMD_SUCCESS = 2'd1;

    // result status codes
    localparam logic [3:0] ST_NEW       = 4'd0;
    localparam logic [3:0] ST_COUNTED   = 4'd1;
    localparam logic [3:0] ST_RESTART   = 4'd2;
    localparam logic [3:0] ST_BLOCKED   = 4'd3;
    localparam logic [3:0] ST_STILL     = 4'd4;
    localparam logic [3:0] ST_EXTENDED  = 4'd5;
    localparam logic [3:0] ST_UNBLOCKED = 4'd6;
    localparam logic [3:0] ST_FULL      = 4'd7;
    localparam logic [3:0] ST_SUCCESS   = 4'd8;
    localparam logic [3:0] ST_IGNORED   = 4'd9;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK  = 2'd2;

    localparam logic [7:0]  LIMIT_RESET  = 8'd5;
    localparam logic [15:0] WINDOW_RESET = 16'd900;
    localparam logic [15:0] BLOCK_RESET  = 16'd300;

    typedef struct packed {
        logic [7:0]  limit;
        logic [15:0] window;
        logic [15:0] block;
    } cfg_t;

    // one table record besides the key
    typedef struct packed {
        logic [TIME_W-1:0]  window_start;
        logic [COUNT_W-1:0] count;
        logic               blocked;
        logic [TIME_W-1:0]  block_end;
    } rec_t;

    // first-stage differences taken from the fetched record
    typedef struct packed {
        logic [TIME_W:0] win_diff;  // now - window_start, borrow on top
        logic [TIME_W:0] left;      // block_end - now, borrow on top
        logic            cnt_ge;    // count at or above the limit
    } prep_t;

    typedef struct packed {
        logic              allowed;
        logic [3:0]        status;
        logic [TIME_W-1:0] remain;
        logic              key_we;
        logic              rec_we;
        rec_t              rec;
    } dec_t;

endpackage

// File: sv/psal_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module psal_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/psal_cfg.sv
// Configuration registers of the attempt limiter (limit, window, block length).
// Depends on psal_pkg.
module psal_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [psal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [psal_pkg::CFG_W-1:0]        cfg_wdata,
    output psal_pkg::cfg_t                    cfg
);

    psal_pkg::cfg_t cfg_reg;
    psal_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                psal_pkg::CFG_LIMIT:  cfg_next.limit  = cfg_wdata[7:0];
                psal_pkg::CFG_WINDOW: cfg_next.window = cfg_wdata;
                psal_pkg::CFG_BLOCK:  cfg_next.block  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit  <= psal_pkg::LIMIT_RESET;
            cfg_reg.window <= psal_pkg::WINDOW_RESET;
            cfg_reg.block  <= psal_pkg::BLOCK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/psal_decide.sv
// Decision and record update for one request, from the looked-up record.
// Depends on psal_pkg.
module psal_decide (
    input  logic [1:0]                    cmd,
    input  logic [psal_pkg::TIME_W-1:0]   now,
    input  logic                          found,
    input  logic                          full,
    input  psal_pkg::rec_t                rec,
    input  psal_pkg::prep_t               prep,
    input  psal_pkg::cfg_t                cfg,
    output psal_pkg::dec_t                dec
);

    logic                          win_exp;
    logic                          before_end;
    logic [psal_pkg::TIME_W-1:0]   headroom;
    logic [psal_pkg::TIME_W:0]     dbl_left;
    logic [psal_pkg::TIME_W-1:0]   rem_ext;
    logic [psal_pkg::TIME_W-1:0]   rem_blk;
    logic [psal_pkg::COUNT_W-1:0]  cnt_inc;

    always_comb begin
        win_exp    = !prep.win_diff[psal_pkg::TIME_W]
                     && (prep.win_diff[psal_pkg::TIME_W-1:0]
                         > {16'd0, cfg.window});
        before_end = !prep.left[psal_pkg::TIME_W]
                     && (prep.left[psal_pkg::TIME_W-1:0] != '0);
        // room left before the time range saturates
        headroom   = ~now;
        dbl_left   = {prep.left[psal_pkg::TIME_W-1:0], 1'b0};
        rem_ext    = (dbl_left > {1'b0, headroom}) ? headroom
                                                   : dbl_left[psal_pkg::TIME_W-1:0];
        rem_blk    = ({16'd0, cfg.block} > headroom) ? headroom : {16'd0, cfg.block};
        cnt_inc    = (rec.count == '1) ? rec.count : rec.count + 8'd1;
    end

    always_comb begin
        dec.allowed = 1'b0;
        dec.status  = psal_pkg::ST_IGNORED;
        dec.remain  = '0;
        dec.key_we  = 1'b0;
        dec.rec_we  = 1'b0;
        dec.rec     = rec;
        case (cmd)
            psal_pkg::CMD_SUCCESS: begin
                if (found) begin
                    dec.rec.count        = '0;
                    dec.rec.window_start = now;
                    dec.rec_we           = 1'b1;
                    dec.status           = psal_pkg::ST_SUCCESS;
                end
            end
            psal_pkg::CMD_CHECK: begin
                dec.rec_we = 1'b1;
                if (!found) begin
                    dec.allowed = 1'b1;
                    dec.rec.window_start = now;
                    dec.rec.count        = 8'd1;
                    dec.rec.blocked      = 1'b0;
                    dec.rec.block_end    = '0;
                    if (full) begin
                        dec.rec_we = 1'b0;
                        dec.status = psal_pkg::ST_FULL;
                    end else begin
                        dec.key_we = 1'b1;
                        dec.status = psal_pkg::ST_NEW;
                    end
                end else if (rec.blocked) begin
                    if (before_end) begin
                        if (prep.cnt_ge) begin
                            // double what is left of the block, restart the count
                            dec.rec.block_end = now + rem_ext;
                            dec.rec.count     = 8'd1;
                            dec.remain        = rem_ext;
                            dec.status        = psal_pkg::ST_EXTENDED;
                        end else begin
                            dec.rec.count = cnt_inc;
                            dec.remain    = prep.left[psal_pkg::TIME_W-1:0];
                            dec.status    = psal_pkg::ST_STILL;
                        end
                    end else begin
                        dec.rec.blocked      = 1'b0;
                        dec.rec.count        = '0;
                        dec.rec.window_start = now;
                        dec.allowed          = 1'b1;
                        dec.status           = psal_pkg::ST_UNBLOCKED;
                    end
                end else if (win_exp) begin
                    dec.rec.count        = 8'd1;
                    dec.rec.window_start = now;
                    dec.allowed          = 1'b1;
                    dec.status           = psal_pkg::ST_RESTART;
                end else if (prep.cnt_ge) begin
                    dec.rec.blocked   = 1'b1;
                    dec.rec.block_end = now + rem_blk;
                    dec.remain        = rem_blk;
                    dec.status        = psal_pkg::ST_BLOCKED;
                end else begin
                    dec.rec.count = cnt_inc;
                    dec.allowed   = 1'b1;
                    dec.status    = psal_pkg::ST_COUNTED;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/per_source_attempt_limiter_top.sv
// Top level of the per-source attempt limiter: sequencer, key and record RAMs.
// Depends on psal_pkg, psal_ram, psal_cfg and psal_decide.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  request  | s_valid / s_ready   | s_command, s_source_key, s_now_seconds
//  result   | m_valid / m_ready   | m_allowed, m_status, m_block_remaining
//  config   | cfg_wr_en           | cfg_addr, cfg_wdata
//
// A request scans the key RAM one entry a cycle over its single read port;
// when the key is found, the record RAM is then read, the record is
// evaluated and written back. When the key is absent, the request goes
// straight to evaluation without a record read.
// Reset clears the fill count and the control state; the RAMs need no clearing.
// A finished result waits in the output register; a new request is taken as
// soon as the sequencer is idle, and a full output register holds evaluation.
module per_source_attempt_limiter_top #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [31:0]                       s_source_key,
    input  logic [31:0]                       s_now_seconds,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_allowed,
    output logic [3:0]                        m_status,
    output logic [31:0]                       m_block_remaining,
    input  logic                              cfg_wr_en,
    input  logic [psal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [psal_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned REC_W = $bits(psal_pkg::rec_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_PREP,
        S_EVAL
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              used_reg, used_next;
    logic [CNT_W-1:0]              iss_reg, iss_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                          found_reg, found_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [1:0]                    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic [31:0]                   now_reg, now_next;
    psal_pkg::prep_t               prep_reg, prep_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_allowed_reg, m_allowed_next;
    logic [3:0]                    m_status_reg, m_status_next;
    logic [31:0]                   m_remain_reg, m_remain_next;

    psal_pkg::cfg_t                cfg;
    psal_pkg::dec_t                dec;
    psal_pkg::rec_t                rec_rdata;
    logic [REC_W-1:0]              rec_rdata_bits;
    logic [KEY_BITS-1:0]           key_rdata;

    logic                          issue;
    logic                          key_rd_en;
    logic                          rec_rd_en;
    logic                          out_free;
    logic                          commit;
    logic                          full;

    psal_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    psal_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (commit && dec.key_we),
        .wr_addr (used_reg[IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (key_rdata)
    );

    psal_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (commit && dec.rec_we),
        .wr_addr (dec.key_we ? used_reg[IDX_W-1:0] : idx_reg),
        .wr_data (dec.rec),
        .rd_en   (rec_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rec_rdata_bits)
    );

    assign rec_rdata = psal_pkg::rec_t'(rec_rdata_bits);

    psal_decide u_decide (
        .cmd   (cmd_reg),
        .now   (now_reg),
        .found (found_reg),
        .full  (full),
        .rec   (rec_rdata),
        .prep  (prep_reg),
        .cfg   (cfg),
        .dec   (dec)
    );

    always_comb begin
        full      = (used_reg >= CNT_W'(TABLE_ENTRIES));
        issue     = (iss_reg < used_reg);
        key_rd_en = (state_reg == S_SEARCH) && issue;
        rec_rd_en = (state_reg == S_FETCH);
        out_free  = !m_valid_reg || m_ready;
        commit    = (state_reg == S_EVAL) && out_free;
        s_ready   = (state_reg == S_IDLE);

        state_next     = state_reg;
        used_next      = used_reg;
        iss_next       = iss_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        prep_next      = prep_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_allowed_next = m_allowed_reg;
        m_status_next  = m_status_reg;
        m_remain_next  = m_remain_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_command;
                    key_next     = KEY_BITS'(s_source_key);
                    now_next     = s_now_seconds;
                    iss_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // one key read issued per cycle, compared the cycle after
                if (key_rd_en) begin
                    iss_next = iss_reg + 1'b1;
                end
                cmp_vld_next = key_rd_en;
                cmp_idx_next = iss_reg[IDX_W-1:0];
                if (cmp_vld_reg && (key_rdata == key_reg)) begin
                    found_next = 1'b1;
                    idx_next   = cmp_idx_reg;
                    state_next = S_FETCH;
                end else if (!cmp_vld_reg && !issue) begin
                    found_next = 1'b0;
                    state_next = S_EVAL;
                end
            end
            S_FETCH: begin
                state_next = S_PREP;
            end
            S_PREP: begin
                prep_next.win_diff = {1'b0, now_reg} - {1'b0, rec_rdata.window_start};
                prep_next.left     = {1'b0, rec_rdata.block_end} - {1'b0, now_reg};
                prep_next.cnt_ge   = (rec_rdata.count >= cfg.limit);
                state_next         = S_EVAL;
            end
            S_EVAL: begin
                // hold until the output register can take the result
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_allowed_next = dec.allowed;
                    m_status_next  = dec.status;
                    m_remain_next  = dec.remain;
                    if (dec.key_we) begin
                        used_next = used_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            iss_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            iss_reg     <= iss_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        cmp_idx_reg   <= cmp_idx_next;
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        now_reg       <= now_next;
        prep_reg      <= prep_next;
        m_allowed_reg <= m_allowed_next;
        m_status_reg  <= m_status_next;
        m_remain_reg  <= m_remain_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_allowed         = m_allowed_reg;
    assign m_status          = m_status_reg;
    assign m_block_remaining = m_remain_reg;

endmodule
